FILE: src/ksat_pkg.sv
// Shared types and constants for the keyed sales aggregation table.
// Used by the table cell and by the top level; depends on nothing.
`default_nettype none

package ksat_pkg;

	localparam int KEY_W = 16;
	localparam int OCC_W = 24;
	localparam int QTY_W = 32;
	localparam int AMT_W = 48;
	localparam int IN_QTY_W = 16;
	localparam int IN_AMT_W = 32;

	localparam logic [OCC_W-1:0] OCC_MAX = '1;
	localparam logic [QTY_W-1:0] QTY_MAX = '1;
	localparam logic [AMT_W-1:0] AMT_MAX = '1;

	localparam logic OP_RECORD = 1'b0;
	localparam logic OP_DRAIN  = 1'b1;

	typedef enum logic [2:0] {
		STS_UPDATED = 3'd0,
		STS_CREATED = 3'd1,
		STS_DROPPED = 3'd2,
		STS_REPORT  = 3'd3,
		STS_EMPTY   = 3'd4
	} status_t;

	typedef enum logic [1:0] {
		CMD_HOLD,
		CMD_UPDATE,
		CMD_INSERT,
		CMD_SHIFT
	} cell_cmd_t;

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_CMP,
		ST_APPLY,
		ST_DRAIN
	} state_t;

	typedef struct packed {
		logic                operation;
		logic [KEY_W-1:0]    product_code;
		logic [IN_QTY_W-1:0] quantity;
		logic [IN_AMT_W-1:0] amount;
	} item_t;

	typedef struct packed {
		logic [2:0]       status;
		logic [KEY_W-1:0] key_out;
		logic [OCC_W-1:0] occurrences;
		logic [QTY_W-1:0] total_quantity;
		logic [AMT_W-1:0] total_amount;
		logic             last;
	} result_t;

	typedef struct packed {
		logic             valid;
		logic [KEY_W-1:0] code;
		logic [OCC_W-1:0] occ;
		logic [QTY_W-1:0] qty;
		logic [AMT_W-1:0] amt;
	} entry_t;

	// Broadcast from the sequencer to every cell.
	typedef struct packed {
		cell_cmd_t           cmd;
		logic [KEY_W-1:0]    key;
		logic [IN_QTY_W-1:0] qty;
		logic [IN_AMT_W-1:0] amt;
	} cell_ctl_t;

endpackage

`default_nettype wire

FILE: src/ksat_cell.sv
// One cell of the sorted aggregation chain: holds a single table entry.
// Depends on ksat_pkg for the entry, command and control types.
`default_nettype none

module ksat_cell (
	input  wire                 clk,
	input  wire                 arst_n,
	input  ksat_pkg::cell_ctl_t ctl,
	input  ksat_pkg::entry_t    prev_ent,
	input  wire                 prev_after,
	input  ksat_pkg::entry_t    next_ent,
	output ksat_pkg::entry_t    ent,
	output logic                after,
	output logic                hit,
	output ksat_pkg::entry_t    upd
);
	import ksat_pkg::*;

	logic             valid_q;
	logic [KEY_W-1:0] code_q;
	logic [OCC_W-1:0] occ_q;
	logic [QTY_W-1:0] qty_q;
	logic [AMT_W-1:0] amt_q;
	logic             after_s1;
	logic             hit_s1;

	logic             after_c;
	logic             hit_c;
	logic [OCC_W-1:0] occ_n;
	logic [QTY_W:0]   qty_sum;
	logic [AMT_W:0]   amt_sum;
	logic [QTY_W-1:0] qty_n;
	logic [AMT_W-1:0] amt_n;
	entry_t           ent_d;

	assign ent = '{valid: valid_q, code: code_q, occ: occ_q, qty: qty_q, amt: amt_q};

	// A new key goes in front of this cell when the cell is empty or holds a larger key.
	always_comb begin
		after_c = !valid_q || (code_q > ctl.key);
		hit_c   = valid_q && (code_q == ctl.key);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			after_s1 <= 1'b0;
			hit_s1   <= 1'b0;
		end else begin
			after_s1 <= after_c;
			hit_s1   <= hit_c;
		end
	end

	assign after = after_s1;
	assign hit   = hit_s1;

	always_comb begin
		occ_n   = (occ_q == OCC_MAX) ? occ_q : occ_q + OCC_W'(1);
		qty_sum = {1'b0, qty_q} + (QTY_W + 1)'(ctl.qty);
		amt_sum = {1'b0, amt_q} + (AMT_W + 1)'(ctl.amt);
		qty_n   = qty_sum[QTY_W] ? QTY_MAX : qty_sum[QTY_W-1:0];
		amt_n   = amt_sum[AMT_W] ? AMT_MAX : amt_sum[AMT_W-1:0];
	end

	always_comb begin
		if (hit_s1) begin
			upd = '{valid: 1'b1, code: code_q, occ: occ_n, qty: qty_n, amt: amt_n};
		end else begin
			upd = '0;
		end
	end

	always_comb begin
		ent_d = ent;
		case (ctl.cmd)
			CMD_UPDATE: begin
				if (hit_s1) begin
					ent_d = upd;
				end
			end
			CMD_INSERT: begin
				if (prev_after) begin
					ent_d = prev_ent;
				end else if (after_s1) begin
					ent_d = '{valid: 1'b1, code: ctl.key, occ: OCC_W'(1),
						qty: QTY_W'(ctl.qty), amt: AMT_W'(ctl.amt)};
				end
			end
			CMD_SHIFT: ent_d = next_ent;
			default: ent_d = ent;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else begin
			valid_q <= ent_d.valid;
		end
	end

	always_ff @(posedge clk) begin
		code_q <= ent_d.code;
		occ_q  <= ent_d.occ;
		qty_q  <= ent_d.qty;
		amt_q  <= ent_d.amt;
	end

endmodule

`default_nettype wire

FILE: src/keyed_sales_aggregation_table_unit.sv
// Top level of the keyed sales aggregation table: sequencer, result register
// and the chain of ksat_cell instances. Depends on ksat_pkg and ksat_cell.
`default_nettype none

// The table is a chain of TABLE_ENTRIES cells kept sorted by product code,
// valid entries packed at the low end. A record is first compared against
// every cell in parallel (the flags are registered in the cells), then
// applied: it updates the matching cell, opens a slot by shifting the larger
// entries one cell up, or is dropped when the table is full. The next record
// is taken while the current one is applied, as long as results are taken. A
// drain shifts the chain down one cell a cycle and delivers one report entry
// per cycle while results are taken, or one empty status for an empty table,
// leaving the table empty; records are held off until the drain's last result
// is out. A result waits in an output register, so a stalled result costs at
// most one record of slack. Reset clears the valid bits directly; there is no
// clearing pass.
module keyed_sales_aggregation_table_unit #(
	parameter int TABLE_ENTRIES = 64
) (
	input  wire               clk,
	input  wire               arst_n,
	input  wire               item_valid,
	output logic              item_stall,
	input  ksat_pkg::item_t   item,
	output logic              result_valid,
	input  wire               result_stall,
	output ksat_pkg::result_t result
);
	import ksat_pkg::*;

	state_t    state_q;
	state_t    state_d;
	item_t     item_q;
	result_t   res_q;
	result_t   res_d;
	logic      res_valid_q;
	logic      res_load;
	logic      out_free;
	logic      accept;
	cell_ctl_t ctl;
	cell_cmd_t cmd;

	entry_t                   ent_vec [TABLE_ENTRIES];
	entry_t                   upd_vec [TABLE_ENTRIES];
	logic [TABLE_ENTRIES-1:0] after_vec;
	logic [TABLE_ENTRIES-1:0] hit_vec;
	logic [TABLE_ENTRIES-1:0] vld_vec;
	entry_t                   hit_ent;
	logic                     hit_any;
	logic                     full;

	assign out_free = !res_valid_q || !result_stall;
	assign item_stall = !((state_q == ST_IDLE) || ((state_q == ST_APPLY) && out_free));
	assign accept = item_valid && !item_stall;

	assign ctl = '{cmd: cmd, key: item_q.product_code, qty: item_q.quantity,
		amt: item_q.amount};

	genvar gi;
	generate
		for (gi = 0; gi < TABLE_ENTRIES; gi++) begin : g_cell
			entry_t prev_ent;
			logic   prev_after;
			entry_t next_ent;

			if (gi == 0) begin : g_first
				assign prev_ent   = '0;
				assign prev_after = 1'b0;
			end else begin : g_link_prev
				assign prev_ent   = ent_vec[gi-1];
				assign prev_after = after_vec[gi-1];
			end

			if (gi == TABLE_ENTRIES - 1) begin : g_last
				assign next_ent = '0;
			end else begin : g_link_next
				assign next_ent = ent_vec[gi+1];
			end

			ksat_cell u_cell (
				.clk        (clk),
				.arst_n     (arst_n),
				.ctl        (ctl),
				.prev_ent   (prev_ent),
				.prev_after (prev_after),
				.next_ent   (next_ent),
				.ent        (ent_vec[gi]),
				.after      (after_vec[gi]),
				.hit        (hit_vec[gi]),
				.upd        (upd_vec[gi])
			);

			assign vld_vec[gi] = ent_vec[gi].valid;
		end
	endgenerate

	// At most one cell matches, so the masked updates can simply be ORed.
	always_comb begin
		hit_ent = '0;
		for (int i = 0; i < TABLE_ENTRIES; i++) begin
			hit_ent = hit_ent | upd_vec[i];
		end
	end

	assign hit_any = |hit_vec;
	assign full    = vld_vec[TABLE_ENTRIES-1];

	always_ff @(posedge clk) begin
		if (accept) begin
			item_q <= item;
		end
	end

	always_comb begin
		state_d = state_q;
		case (state_q)
			ST_IDLE: begin
				if (accept) begin
					state_d = (item.operation == OP_DRAIN) ? ST_DRAIN : ST_CMP;
				end
			end
			ST_CMP: state_d = ST_APPLY;
			ST_APPLY: begin
				if (out_free) begin
					if (accept) begin
						state_d = (item.operation == OP_DRAIN) ? ST_DRAIN : ST_CMP;
					end else begin
						state_d = ST_IDLE;
					end
				end
			end
			ST_DRAIN: begin
				if (out_free && (!vld_vec[0] || !vld_vec[1])) begin
					state_d = ST_IDLE;
				end
			end
			default: state_d = ST_IDLE;
		endcase
	end

	always_comb begin
		cmd      = CMD_HOLD;
		res_load = 1'b0;
		res_d    = '0;
		case (state_q)
			ST_APPLY: begin
				if (out_free) begin
					res_load      = 1'b1;
					res_d.key_out = item_q.product_code;
					res_d.last    = 1'b1;
					if (hit_any) begin
						cmd                  = CMD_UPDATE;
						res_d.status         = STS_UPDATED;
						res_d.occurrences    = hit_ent.occ;
						res_d.total_quantity = hit_ent.qty;
						res_d.total_amount   = hit_ent.amt;
					end else if (!full) begin
						cmd                  = CMD_INSERT;
						res_d.status         = STS_CREATED;
						res_d.occurrences    = OCC_W'(1);
						res_d.total_quantity = QTY_W'(item_q.quantity);
						res_d.total_amount   = AMT_W'(item_q.amount);
					end else begin
						res_d.status = STS_DROPPED;
					end
				end
			end
			ST_DRAIN: begin
				if (out_free) begin
					res_load = 1'b1;
					if (vld_vec[0]) begin
						cmd                  = CMD_SHIFT;
						res_d.status         = STS_REPORT;
						res_d.key_out        = ent_vec[0].code;
						res_d.occurrences    = ent_vec[0].occ;
						res_d.total_quantity = ent_vec[0].qty;
						res_d.total_amount   = ent_vec[0].amt;
						res_d.last           = !vld_vec[1];
					end else begin
						res_d.status = STS_EMPTY;
						res_d.last   = 1'b1;
					end
				end
			end
			default: begin
				cmd      = CMD_HOLD;
				res_load = 1'b0;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			res_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (res_load) begin
				res_valid_q <= 1'b1;
			end else if (!result_stall) begin
				res_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (res_load) begin
			res_q <= res_d;
		end
	end

	assign result_valid = res_valid_q;
	assign result       = res_q;

	// A code is held in at most one cell.
	a_single_hit: assert property (@(posedge clk) disable iff (!arst_n)
		$onehot0(hit_vec))
		else $error("more than one cell matches the record code");

	// Valid entries stay packed at the low end of the chain.
	a_packed: assert property (@(posedge clk) disable iff (!arst_n)
		((vld_vec >> 1) & ~vld_vec) == '0)
		else $error("valid entry above an empty cell");

	// An insert never pushes an entry off the end of the chain.
	a_insert_room: assert property (@(posedge clk) disable iff (!arst_n)
		(cmd == CMD_INSERT) |-> !full)
		else $error("insert into a full table");

	// A drain leaves the table empty.
	a_drain_clears: assert property (@(posedge clk) disable iff (!arst_n)
		((state_q == ST_DRAIN) && (state_d == ST_IDLE)) |=> !vld_vec[0])
		else $error("table not empty after drain");

endmodule

`default_nettype wire
